/* sv/s2c_pkg.sv */
`default_nettype none
package s2c_pkg;

    // configuration register indexes
    localparam logic REG_COORD_SYSTEM = 1'b0;
    localparam logic REG_POINT_DIMS   = 1'b1;

    // coordinate system codes
    localparam logic [1:0] CS_CART = 2'd0;
    localparam logic [1:0] CS_DEG  = 2'd1;
    localparam logic [1:0] CS_RAD  = 2'd2;

    // angle conversion to binary angle (2^32 per turn)
    localparam logic [32:0] DEG_TO_BIN = 33'd3054198966;
    localparam logic [32:0] RAD_TO_BIN = 33'd2734261102;

    // cordic start value, 0.60725293 in Q2.30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         result_dims;
        logic               bad_dims;
    } t_out;

    // classified point handed from front to back
    typedef struct packed {
        logic               sph;
        logic               scaled;
        logic [31:0]        th;
        logic [31:0]        ph;
        logic signed [31:0] radius;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [1:0]         dims;
        logic               bad;
    } t_job;

endpackage
`default_nettype wire

/* sv/s2c_front.sv */
`default_nettype none
module s2c_front #(
    parameter int CW = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [1:0]        i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  s2c_pkg::t_in     i_in_data,
    output logic             o_job_valid,
    input  wire              i_job_ready,
    output s2c_pkg::t_job    o_job
);

    logic [1:0]    r_coord_system;
    logic [1:0]    r_point_dims;
    logic          r_v;
    s2c_pkg::t_job r_job;
    s2c_pkg::t_job n_job;

    logic signed [31:0] a_s, b_s, c_s;
    logic               deg, sph;
    logic signed [65:0] k_mul, pa, pb, sa, sb, half;
    logic [31:0]        bin_a, bin_b;

    function automatic logic signed [31:0] sext(input logic [31:0] v);
        logic signed [CW-1:0] t;
        t = v[CW-1:0];
        return 32'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_system <= s2c_pkg::CS_CART;
            r_point_dims   <= 2'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == s2c_pkg::REG_COORD_SYSTEM) begin
                r_coord_system <= i_cfg_data;
            end else begin
                r_point_dims <= i_cfg_data;
            end
        end
    end

    always_comb begin
        a_s   = sext(i_in_data.coord_a);
        b_s   = sext(i_in_data.coord_b);
        c_s   = sext(i_in_data.coord_c);
        deg   = (r_coord_system == s2c_pkg::CS_DEG);
        sph   = deg || (r_coord_system == s2c_pkg::CS_RAD);
        k_mul = deg ? $signed(66'(s2c_pkg::DEG_TO_BIN)) : $signed(66'(s2c_pkg::RAD_TO_BIN));
        half  = deg ? 66'sd8388608 : 66'sd131072;
        pa    = 66'(a_s) * k_mul;
        pb    = 66'(b_s) * k_mul;
        sa    = pa + half;
        sb    = pb + half;
        bin_a = deg ? sa[55:24] : sa[49:18];
        bin_b = deg ? sb[55:24] : sb[49:18];

        n_job        = '0;
        n_job.th     = bin_a;
        n_job.ph     = 32'h4000_0000 - bin_b;
        n_job.radius = c_s;
        if (sph) begin
            if (r_point_dims == 2'd2 || r_point_dims == 2'd3) begin
                n_job.sph    = 1'b1;
                n_job.scaled = (r_point_dims == 2'd3);
                n_job.dims   = 2'd3;
            end else begin
                n_job.bad = 1'b1;
            end
        end else begin
            n_job.dims = r_point_dims;
            n_job.cx   = (r_point_dims >= 2'd1) ? a_s : '0;
            n_job.cy   = (r_point_dims >= 2'd2) ? b_s : '0;
            n_job.cz   = (r_point_dims == 2'd3) ? c_s : '0;
        end
    end

    assign o_in_ready  = !r_v || i_job_ready;
    assign o_job_valid = r_v;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

/* sv/s2c_fifo.sv */
`default_nettype none
module s2c_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  s2c_pkg::t_job    i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output s2c_pkg::t_job    o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    s2c_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count past depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_wp - r_rp) == r_cnt[AW-1:0])
        else $error("queue pointers disagree with count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !(i_pop && !o_empty)) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");

endmodule
`default_nettype wire

/* sv/s2c_back.sv */
`default_nettype none
module s2c_back #(
    parameter int CW     = 32,
    parameter int STAGES = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  s2c_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output s2c_pkg::t_out    o_out_data
);

    typedef struct packed {
        logic               sph;
        logic               scaled;
        logic signed [31:0] radius;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [1:0]         dims;
        logic               bad;
    } t_side;

    typedef struct packed {
        t_side              sd;
        logic [1:0]         qt;
        logic [1:0]         qp;
        logic signed [33:0] xt;
        logic signed [33:0] yt;
        logic signed [31:0] zt;
        logic signed [33:0] xp;
        logic signed [33:0] yp;
        logic signed [31:0] zp;
    } t_rot;

    typedef struct packed {
        t_side              sd;
        logic signed [33:0] ct;
        logic signed [33:0] st;
        logic signed [33:0] cp;
        logic signed [33:0] sp;
    } t_trig;

    typedef struct packed {
        t_side              sd;
        logic signed [33:0] pa;
        logic signed [33:0] pb;
        logic signed [33:0] pc;
    } t_prod;

    typedef struct packed {
        t_side              sd;
        logic signed [67:0] ma;
        logic signed [67:0] mb;
        logic signed [67:0] mc;
    } t_rad;

    logic          en;
    logic          r_vr [STAGES+1];
    t_rot          r_rot [STAGES+1];
    t_rot          n_rot [STAGES+1];
    logic          r_vm, r_vp, r_vq, r_ov;
    t_trig         r_trig, n_trig;
    t_prod         r_prod, n_prod;
    t_rad          r_rad, n_rad;
    s2c_pkg::t_out r_out, n_out;
    logic [31:0]   t_sum, p_sum, rt, rp;
    logic [1:0]    qt0, qp0;
    logic signed [67:0] prod_a, prod_b;

    function automatic logic signed [31:0] sat_rnd(input logic signed [67:0] v,
                                                   input logic scaled);
        logic signed [67:0] r;
        logic signed [67:0] hi, lo;
        hi = (68'sd1 <<< (CW-1)) - 68'sd1;
        lo = -(68'sd1 <<< (CW-1));
        r  = scaled ? ((v + 68'sd536870912) >>> 30) : ((v + 68'sd8192) >>> 14);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[31:0];
    endfunction

    function automatic void qmap(input logic [1:0] q, input logic signed [33:0] x,
                                 input logic signed [33:0] y,
                                 output logic signed [33:0] c,
                                 output logic signed [33:0] s);
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // the whole back end advances together whenever the output slot frees
    assign en    = !r_ov || i_out_ready;
    assign o_pop = en && !i_empty;

    // quadrant reduction into the first rotation stage
    always_comb begin
        t_sum = i_job.th + 32'h2000_0000;
        p_sum = i_job.ph + 32'h2000_0000;
        qt0   = t_sum[31:30];
        qp0   = p_sum[31:30];
        rt    = i_job.th - {qt0, 30'b0};
        rp    = i_job.ph - {qp0, 30'b0};
        n_rot[0]           = '0;
        n_rot[0].sd.sph    = i_job.sph;
        n_rot[0].sd.scaled = i_job.scaled;
        n_rot[0].sd.radius = i_job.radius;
        n_rot[0].sd.cx     = i_job.cx;
        n_rot[0].sd.cy     = i_job.cy;
        n_rot[0].sd.cz     = i_job.cz;
        n_rot[0].sd.dims   = i_job.dims;
        n_rot[0].sd.bad    = i_job.bad;
        n_rot[0].qt        = qt0;
        n_rot[0].qp        = qp0;
        n_rot[0].xt        = s2c_pkg::GAIN_Q30;
        n_rot[0].xp        = s2c_pkg::GAIN_Q30;
        n_rot[0].zt        = $signed(rt);
        n_rot[0].zp        = $signed(rp);
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        always_comb begin
            n_rot[i+1] = r_rot[i];
            if (r_rot[i].zt >= 0) begin
                n_rot[i+1].xt = r_rot[i].xt - (r_rot[i].yt >>> i);
                n_rot[i+1].yt = r_rot[i].yt + (r_rot[i].xt >>> i);
                n_rot[i+1].zt = r_rot[i].zt - $signed(s2c_pkg::ATAN_TAB[i]);
            end else begin
                n_rot[i+1].xt = r_rot[i].xt + (r_rot[i].yt >>> i);
                n_rot[i+1].yt = r_rot[i].yt - (r_rot[i].xt >>> i);
                n_rot[i+1].zt = r_rot[i].zt + $signed(s2c_pkg::ATAN_TAB[i]);
            end
            if (r_rot[i].zp >= 0) begin
                n_rot[i+1].xp = r_rot[i].xp - (r_rot[i].yp >>> i);
                n_rot[i+1].yp = r_rot[i].yp + (r_rot[i].xp >>> i);
                n_rot[i+1].zp = r_rot[i].zp - $signed(s2c_pkg::ATAN_TAB[i]);
            end else begin
                n_rot[i+1].xp = r_rot[i].xp + (r_rot[i].yp >>> i);
                n_rot[i+1].yp = r_rot[i].yp - (r_rot[i].xp >>> i);
                n_rot[i+1].zp = r_rot[i].zp + $signed(s2c_pkg::ATAN_TAB[i]);
            end
        end
    end

    for (genvar i = 0; i <= STAGES; i++) begin : g_rot_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vr[i] <= 1'b0;
            end else if (en) begin
                r_vr[i] <= (i == 0) ? !i_empty : r_vr[(i == 0) ? 0 : i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rot[i] <= n_rot[i];
            end
        end
    end

    always_comb begin
        n_trig.sd = r_rot[STAGES].sd;
        qmap(r_rot[STAGES].qt, r_rot[STAGES].xt, r_rot[STAGES].yt, n_trig.ct, n_trig.st);
        qmap(r_rot[STAGES].qp, r_rot[STAGES].xp, r_rot[STAGES].yp, n_trig.cp, n_trig.sp);

        prod_a    = 68'(r_trig.ct) * 68'(r_trig.sp) + 68'sd536870912;
        prod_b    = 68'(r_trig.st) * 68'(r_trig.sp) + 68'sd536870912;
        n_prod.sd = r_trig.sd;
        n_prod.pa = 34'(prod_a >>> 30);
        n_prod.pb = 34'(prod_b >>> 30);
        n_prod.pc = r_trig.cp;

        n_rad.sd = r_prod.sd;
        if (r_prod.sd.scaled) begin
            n_rad.ma = 68'(r_prod.pa) * 68'(r_prod.sd.radius);
            n_rad.mb = 68'(r_prod.pb) * 68'(r_prod.sd.radius);
            n_rad.mc = 68'(r_prod.pc) * 68'(r_prod.sd.radius);
        end else begin
            n_rad.ma = 68'(r_prod.pa);
            n_rad.mb = 68'(r_prod.pb);
            n_rad.mc = 68'(r_prod.pc);
        end

        n_out             = '0;
        n_out.result_dims = r_rad.sd.dims;
        n_out.bad_dims    = r_rad.sd.bad;
        if (r_rad.sd.sph) begin
            n_out.out_x = sat_rnd(r_rad.ma, r_rad.sd.scaled);
            n_out.out_y = sat_rnd(r_rad.mb, r_rad.sd.scaled);
            n_out.out_z = sat_rnd(r_rad.mc, r_rad.sd.scaled);
        end else begin
            n_out.out_x = r_rad.sd.cx;
            n_out.out_y = r_rad.sd.cy;
            n_out.out_z = r_rad.sd.cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vp <= 1'b0;
            r_vq <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vm <= r_vr[STAGES];
            r_vp <= r_vm;
            r_vq <= r_vp;
            r_ov <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trig <= n_trig;
            r_prod <= n_prod;
            r_rad  <= n_rad;
            r_out  <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.bad_dims) |-> (r_out.result_dims == 2'd0 && r_out.out_x == '0
            && r_out.out_y == '0 && r_out.out_z == '0))
        else $error("bad dimension result carries data");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_vm) && $stable(r_vp) && $stable(r_vq)))
        else $error("back end moved while stalled");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !o_pop)
        else $error("queue popped while output stalled");

endmodule
`default_nettype wire

/* sv/spherical_to_cartesian.sv */
// spherical_to_cartesian: converts one point of three signed Q16.16
// coordinates into Cartesian x, y, z
// configuration: write i_cfg_we with i_cfg_idx 0 for the coordinate system
// (0 copy, 1 degrees, 2 radians) or 1 for the point dimension; writes are
// taken at once and must happen while no transaction is in flight
// input channel: i_in_valid / o_in_ready with i_in_data; output channel:
// o_out_valid / i_out_ready with o_out_data
// front: one register stage that sign-extends, classifies and converts the
// angles to binary angles, then a four-entry queue
// back: quadrant reduction, CORDIC_STAGES rotation stages for both angles in
// parallel, quadrant map, trig product, radius product, round/saturate into
// the output register
// throughput: one transaction per cycle, limited by nothing but the handshakes
// reset: queue and all valid bits clear, coordinate system 0, dimension 2
// when the receiver stalls the back end freezes in place, the queue fills,
// then o_in_ready drops; nothing is lost or repeated
`default_nettype none
module spherical_to_cartesian #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [1:0]        i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  s2c_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output s2c_pkg::t_out    o_out_data
);

    // effective coordinate width, values below 16 behave as 16 and values past 32 behave as 32
    localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
    localparam int STAGES = (CORDIC_STAGES < 1) ? 1
                          : ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);

    logic          job_valid, q_full, q_empty, q_pop;
    s2c_pkg::t_job job, q_head;

    s2c_front #(.CW(CW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .i_job_ready (!q_full),
        .o_job       (job)
    );

    // queue between classification and the arithmetic pipe
    s2c_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    s2c_back #(.CW(CW), .STAGES(STAGES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int LATENCY     = 16 + 7;
    localparam int CYCLE_LIMIT = 200000;

    // quarter turn in binary-angle units
    localparam logic [31:0] QTR = 32'h4000_0000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = s2c_pkg::REG_COORD_SYSTEM;
    logic [1:0]    i_cfg_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    s2c_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    s2c_pkg::t_out o_out_data;

    spherical_to_cartesian DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the two registers
    logic [1:0] sys_mode = s2c_pkg::CS_CART;
    logic [1:0] dims_cfg = 2'd2;

    s2c_pkg::t_out expected_points[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 19;
    int          recv_idle_pct = 19;
    int          hold_off_cycles = 0;

    // ---------------- predictor ----------------

    function automatic longint round_shift(longint v, int s);
        longint t;
        t = v + (longint'(1) << (s - 1));
        return t >>> s;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] angle_bin(logic signed [31:0] v, logic deg);
        longint p;
        if (deg) p = round_shift(longint'(v) * longint'(s2c_pkg::DEG_TO_BIN), 24);
        else     p = round_shift(longint'(v) * longint'(s2c_pkg::RAD_TO_BIN), 18);
        return p[31:0];
    endfunction

    // cos and sin in Q2.30 from a binary angle
    task automatic cordic_trig(input logic [31:0] ang, output longint c, output longint s);
        logic [1:0]  q;
        logic [31:0] r;
        longint x, y, z, dx, dy;
        q = 2'((ang + (QTR >> 1)) >> 30);
        r = ang - (32'(q) << 30);
        z = longint'(signed'(r));
        x = longint'(s2c_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(s2c_pkg::ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(s2c_pkg::ATAN_TAB[i]);
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [31:0] scale_out(longint p, logic scaled, logic signed [31:0] rad);
        if (scaled) return sat32(round_shift(p * longint'(rad), 30));
        return sat32(round_shift(p, 14));
    endfunction

    task automatic predict_point(input s2c_pkg::t_in pt, output s2c_pkg::t_out res);
        logic [31:0] th, ph;
        longint ct, st, cp, sp;
        logic deg, scaled;
        res = '0;
        if (sys_mode == s2c_pkg::CS_DEG || sys_mode == s2c_pkg::CS_RAD) begin
            if (dims_cfg == 2'd2 || dims_cfg == 2'd3) begin
                deg = (sys_mode == s2c_pkg::CS_DEG);
                scaled = (dims_cfg == 2'd3);
                th = angle_bin(pt.coord_a, deg);
                ph = QTR - angle_bin(pt.coord_b, deg);
                cordic_trig(th, ct, st);
                cordic_trig(ph, cp, sp);
                res.out_x = scale_out(round_shift(ct * sp, 30), scaled, pt.coord_c);
                res.out_y = scale_out(round_shift(st * sp, 30), scaled, pt.coord_c);
                res.out_z = scale_out(cp, scaled, pt.coord_c);
                res.result_dims = 2'd3;
            end else begin
                res.bad_dims = 1'b1;
            end
        end else begin
            res.result_dims = dims_cfg;
            if (dims_cfg > 0) res.out_x = pt.coord_a;
            if (dims_cfg > 1) res.out_y = pt.coord_b;
            if (dims_cfg > 2) res.out_z = pt.coord_c;
        end
    endtask

    // ---------------- drivers ----------------

    // valid stays high after a transaction until the sender idles or stops
    task automatic send_point(input s2c_pkg::t_in pt);
        s2c_pkg::t_out res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_point(pt, res);
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do @(posedge i_clk); while (!o_in_ready);
        // expectation queued at the accepting edge, before any result of it can appear
        expected_points.push_back(res);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        drain_and_settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == s2c_pkg::REG_COORD_SYSTEM) sys_mode = val;
        else dims_cfg = val;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'(signed'($urandom_range(0, 400 * 65536)) - 200 * 65536);
        endcase
    endfunction

    function automatic s2c_pkg::t_in rand_point();
        s2c_pkg::t_in pt;
        pt.coord_a = rand_coord();
        pt.coord_b = rand_coord();
        // radius mostly small so scaling stays in range
        pt.coord_c = ($urandom_range(3) == 0) ? rand_coord()
                   : 32'(signed'($urandom_range(0, 20 * 65536)) - 10 * 65536);
        return pt;
    endfunction

    // ---------------- receiver and checker ----------------

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        s2c_pkg::t_out exp_pt;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected transaction %p", o_out_data);
            end else begin
                exp_pt = expected_points.pop_front();
                if (o_out_data.out_x !== exp_pt.out_x || o_out_data.out_y !== exp_pt.out_y ||
                    o_out_data.out_z !== exp_pt.out_z ||
                    o_out_data.result_dims !== exp_pt.result_dims ||
                    o_out_data.bad_dims !== exp_pt.bad_dims) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %p actual %p", exp_pt, o_out_data);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_cartesian_copy();
        s2c_pkg::t_in pt;
        for (int d = 0; d < 4; d++) begin
            write_reg(s2c_pkg::REG_POINT_DIMS, 2'(d));
            pt = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
            send_point(pt);
            pt = '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000};
            send_point(pt);
        end
        // unused code 3 copies like mode 0
        write_reg(s2c_pkg::REG_COORD_SYSTEM, 2'd3);
        send_point('{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F});
    endtask

    task automatic test_spherical_directed();
        logic signed [31:0] angles[8] = '{0, 90 << 16, -90 << 16, 180 << 16, 45 << 16,
                                          32'h8000_0000, 32'h7FFF_FFFF, 102944};
        for (int m = 1; m <= 2; m++) begin
            write_reg(s2c_pkg::REG_COORD_SYSTEM, 2'(m));
            write_reg(s2c_pkg::REG_POINT_DIMS, 2'd3);
            for (int i = 0; i < 4; i++)
                send_point('{angles[2 * i], angles[2 * i + 1], 32'sd65536 << 3});
            send_point('{32'h0, 32'h0, 32'h7FFF_FFFF});
            write_reg(s2c_pkg::REG_POINT_DIMS, 2'd2);
            send_point('{angles[4], angles[3], 32'h0});
        end
        // bad spherical dimension
        write_reg(s2c_pkg::REG_POINT_DIMS, 2'd1);
        send_point('{32'h10000, 32'h20000, 32'h30000});
        write_reg(s2c_pkg::REG_POINT_DIMS, 2'd0);
        send_point('{32'h10000, 32'h20000, 32'h30000});
    endtask

    task automatic test_random_points(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                write_reg(s2c_pkg::REG_COORD_SYSTEM, 2'($urandom_range(3)));
                write_reg(s2c_pkg::REG_POINT_DIMS, 2'($urandom_range(3)));
            end
            // one stretch with no idling
            send_idle_pct = (i >= 200 && i < 280) ? 0 : 19;
            recv_idle_pct = send_idle_pct;
            send_point(rand_point());
        end
        send_idle_pct = 19;
        recv_idle_pct = 19;
    endtask

    task automatic test_backpressure();
        write_reg(s2c_pkg::REG_COORD_SYSTEM, s2c_pkg::CS_DEG);
        write_reg(s2c_pkg::REG_POINT_DIMS, 2'd3);
        hold_off_cycles = 80;
        send_idle_pct = 0;
        for (int i = 0; i < 40; i++) send_point(rand_point());
        send_idle_pct = 19;
        // sender pauses until everything is back
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_point(rand_point());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cartesian_copy();
        test_spherical_directed();
        test_backpressure();
        test_random_points(480);
        drain_and_settle();
        if (mismatch_cnt == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
`default_nettype wire

/* filelist.f */
sv/s2c_pkg.sv
sv/s2c_front.sv
sv/s2c_fifo.sv
sv/s2c_back.sv
sv/spherical_to_cartesian.sv
dv/testbench.sv
